>>> rtl/lpq_pkg.sv
// ----------------------------------------------------------------------------
// lpq_pkg
// Shared types and constants for the linked packet queue: slot and count
// widths, opcode and status codes, channel payloads and link memory access.
// ----------------------------------------------------------------------------
package lpq_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [1:0] opcode;
    slot_t      slot_id;
  } lpq_in_t;

  typedef struct packed {
    logic [1:0] status;
    slot_t      popped_slot;
    count_t     entry_count;
  } lpq_out_t;

  typedef struct packed {
    logic  wr_en;
    slot_t wr_addr;
    slot_t wr_data;
    logic  rd_en;
    slot_t rd_addr;
  } lpq_mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_WALK,
    ST_RM_HEAD,
    ST_RM_MID,
    ST_DONE
  } lpq_state_t;

endpackage

>>> rtl/lpq_link_mem.sv
// ----------------------------------------------------------------------------
// lpq_link_mem
// Next-link memory indexed by slot: one write port and one read port, read
// data registered. Contents are not initialized.
// ----------------------------------------------------------------------------
module lpq_link_mem
  import lpq_pkg::*;
(
  input  logic         clk,
  input  lpq_mem_req_t req,
  output slot_t        rd_data
);

  slot_t mem [SLOT_COUNT];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/linked_packet_queue.sv
// ----------------------------------------------------------------------------
// linked_packet_queue
// Push, idle and rejected ops pass from IDLE to DONE and then to the output
// register; pop also passes POP_RD unless it empties the queue, and remove
// walks in WALK one link at a time, bound by the single read port of the link
// memory, then RM_HEAD or RM_MID as needed. Ops are taken only in IDLE; DONE waits on out_stall.
// Reset clears head, tail, count and control; the link memory is not cleared.
// ----------------------------------------------------------------------------
module linked_packet_queue
  import lpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lpq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lpq_out_t out_data
);

  lpq_state_t   state_r, state_nxt;
  slot_t        head_r, head_nxt;
  slot_t        tail_r, tail_nxt;
  count_t       count_r, count_nxt;
  slot_t        cur_r, cur_nxt;
  logic         from_mem_r, from_mem_nxt;
  slot_t        prev_r, prev_nxt;
  count_t       pos_r, pos_nxt;
  slot_t        target_r, target_nxt;
  logic [1:0]   res_status_r, res_status_nxt;
  slot_t        res_popped_r, res_popped_nxt;
  logic         out_valid_r, out_valid_nxt;
  lpq_out_t     out_data_r, out_data_nxt;

  lpq_mem_req_t mem_req;
  slot_t        rd_data;
  slot_t        cur_w;
  count_t       pos_inc_w;
  count_t       count_dec_w;

  lpq_link_mem u_link_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // during the walk the current slot comes straight from the link read
  assign cur_w       = from_mem_r ? rd_data : cur_r;
  assign pos_inc_w   = pos_r + count_t'(1);
  assign count_dec_w = count_r - count_t'(1);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      from_mem_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      from_mem_r  <= from_mem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    pos_r        <= pos_nxt;
    target_r     <= target_nxt;
    res_status_r <= res_status_nxt;
    res_popped_r <= res_popped_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    from_mem_nxt   = from_mem_r;
    prev_nxt       = prev_r;
    pos_nxt        = pos_r;
    target_nxt     = target_r;
    res_status_nxt = res_status_r;
    res_popped_nxt = res_popped_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    mem_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          target_nxt     = in_data.slot_id;
          res_status_nxt = STAT_OK;
          res_popped_nxt = '0;
          state_nxt      = ST_DONE;
          unique case (in_data.opcode)
            OP_PUSH: begin
              if (count_r >= count_t'(SLOT_COUNT)) begin
                res_status_nxt = STAT_NO_SPACE;
              end else begin
                if (count_r == '0) begin
                  head_nxt = in_data.slot_id;
                end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = tail_r;
                  mem_req.wr_data = in_data.slot_id;
                end
                tail_nxt  = in_data.slot_id;
                count_nxt = count_r + count_t'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                res_popped_nxt = head_r;
                count_nxt      = count_dec_w;
                if (count_r == count_t'(1)) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_r;
                  state_nxt       = ST_POP_RD;
                end
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_NOT_FOUND;
              end else begin
                cur_nxt      = head_r;
                from_mem_nxt = 1'b0;
                prev_nxt     = '0;
                pos_nxt      = '0;
                state_nxt    = ST_WALK;
              end
            end
            default: begin
              res_status_nxt = STAT_OK;
            end
          endcase
        end
      end

      ST_POP_RD: begin
        head_nxt  = rd_data;
        state_nxt = ST_DONE;
      end

      ST_WALK: begin
        cur_nxt      = cur_w;
        from_mem_nxt = 1'b0;
        if (cur_w == target_r) begin
          if (count_r == count_t'(1)) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = count_dec_w;
            state_nxt = ST_DONE;
          end else if (pos_r == '0) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = cur_w;
            state_nxt       = ST_RM_HEAD;
          end else if (pos_inc_w == count_r) begin
            tail_nxt  = prev_r;
            count_nxt = count_dec_w;
            state_nxt = ST_DONE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = cur_w;
            state_nxt       = ST_RM_MID;
          end
        end else if (pos_inc_w < count_r) begin
          // follow the link; the successor arrives next cycle
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cur_w;
          prev_nxt        = cur_w;
          pos_nxt         = pos_inc_w;
          from_mem_nxt    = 1'b1;
        end else begin
          res_status_nxt = STAT_NOT_FOUND;
          state_nxt      = ST_DONE;
        end
      end

      ST_RM_HEAD: begin
        head_nxt  = rd_data;
        count_nxt = count_dec_w;
        state_nxt = ST_DONE;
      end

      ST_RM_MID: begin
        // unlink from the middle: predecessor skips over the removed slot
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = prev_r;
        mem_req.wr_data = rd_data;
        count_nxt       = count_dec_w;
        state_nxt       = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.popped_slot = res_popped_r;
          out_data_nxt.entry_count = count_r;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
